FILE: hdl/rv32_mini_execute_step_macros.svh
// Assertion macros shared by the execute step RTL.
`ifndef RV32_MINI_EXECUTE_STEP_MACROS_SVH
`define RV32_MINI_EXECUTE_STEP_MACROS_SVH

// Check a condition in the same cycle as its trigger.
`define RVX_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Check a condition in the cycle after its trigger.
`define RVX_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hdl/rvx_pkg.sv
// Package with widths, opcodes, structs and immediate helpers of the execute step.
package rvx_pkg;

  localparam int XLEN       = 32;
  localparam int REG_COUNT  = 32;
  localparam int REG_IDX_W  = 5;
  localparam int CAUSE_W    = 4;
  localparam int CFG_ADDR_W = 3;

  localparam logic [XLEN-1:0] RESET_VECTOR = 32'h8000_0000;
  localparam logic [XLEN-1:0] UPPER_MASK   = 32'hffff_f000;
  localparam logic [XLEN-1:0] PC_STEP      = 32'd4;

  localparam logic [6:0] OP_ADDI = 7'h13;
  localparam logic [6:0] OP_ADD  = 7'h33;
  localparam logic [6:0] OP_LUI  = 7'h37;
  localparam logic [6:0] OP_JAL  = 7'h6f;

  localparam logic [2:0] F3_ADD = 3'd0;
  localparam logic [6:0] F7_ADD = 7'd0;

  localparam logic [CAUSE_W-1:0] CAUSE_NONE    = 4'd0;
  localparam logic [CAUSE_W-1:0] CAUSE_ILLEGAL = 4'd2;

  // Register index on the configuration port (paddr bits above the byte offset)
  localparam logic [CFG_ADDR_W-3:0] CFG_REG_START = '0;

  typedef struct packed {
    logic                 en;
    logic [REG_IDX_W-1:0] idx1;
    logic [REG_IDX_W-1:0] idx2;
  } rf_rd_t;

  typedef struct packed {
    logic [XLEN-1:0] d1;
    logic [XLEN-1:0] d2;
  } rf_data_t;

  typedef struct packed {
    logic                 en;
    logic [REG_IDX_W-1:0] idx;
    logic [XLEN-1:0]      data;
  } rf_wr_t;

  typedef struct packed {
    logic            load;
    logic [XLEN-1:0] value;
  } pc_load_t;

  typedef struct packed {
    logic fire;
    logic legal;
  } exec_stat_t;

  function automatic logic [XLEN-1:0] imm_i(input logic [XLEN-1:0] w);
    return {{20{w[31]}}, w[31:20]};
  endfunction

  function automatic logic [XLEN-1:0] imm_j(input logic [XLEN-1:0] w);
    return {{12{w[31]}}, w[19:12], w[20], w[30:21], 1'b0};
  endfunction

endpackage

FILE: hdl/rvx_instr_if.sv
// Instruction request channel: valid, ready and the instruction word.
interface rvx_instr_if import rvx_pkg::*; ();
  logic            valid;
  logic            ready;
  logic [XLEN-1:0] instruction;

  modport source (output valid, output instruction, input ready);
  modport sink   (input valid, input instruction, output ready);
endinterface

FILE: hdl/rvx_result_if.sv
// Result channel: valid, ready and the fields of one executed instruction.
interface rvx_result_if import rvx_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [XLEN-1:0]      executed_address;
  logic [XLEN-1:0]      fetch_address;
  logic                 write_enable;
  logic [REG_IDX_W-1:0] dest_index;
  logic [XLEN-1:0]      write_value;
  logic                 trap_taken;
  logic [CAUSE_W-1:0]   trap_cause;
  logic [XLEN-1:0]      trap_value;

  modport source (output valid, output executed_address, output fetch_address,
                  output write_enable, output dest_index, output write_value,
                  output trap_taken, output trap_cause, output trap_value,
                  input ready);
  modport sink   (input valid, input executed_address, input fetch_address,
                  input write_enable, input dest_index, input write_value,
                  input trap_taken, input trap_cause, input trap_value,
                  output ready);
endinterface

FILE: hdl/rvx_regfile.sv
// Register file: synchronous memory, one write and two registered read ports.
module rvx_regfile import rvx_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  rf_rd_t   rd_req,
  input  rf_wr_t   wr_req,
  output rf_data_t rd_data
);

  logic [XLEN-1:0]      mem [REG_COUNT];
  logic [REG_COUNT-1:0] valid_r;
  logic [XLEN-1:0]      q1_r, q2_r;
  logic                 v1_r, v2_r;

  always_ff @(posedge clk) begin
    if (wr_req.en) begin
      mem[wr_req.idx] <= wr_req.data;
    end
  end

  // Entries never written read as zero; entry 0 is never written
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (wr_req.en) begin
      valid_r[wr_req.idx] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_req.en) begin
      q1_r <= mem[rd_req.idx1];
      q2_r <= mem[rd_req.idx2];
      v1_r <= valid_r[rd_req.idx1];
      v2_r <= valid_r[rd_req.idx2];
    end
  end

  assign rd_data.d1 = v1_r ? q1_r : '0;
  assign rd_data.d2 = v2_r ? q2_r : '0;

endmodule

FILE: hdl/rvx_exec_stage.sv
// Execute stage: decode, operand bypass, ALU, program counter and result register.
module rvx_exec_stage import rvx_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  rvx_instr_if.sink          in_req,
  rvx_result_if.source       out_res,
  input  pc_load_t           pc_load,
  input  rf_data_t           rd_data,
  output rf_rd_t             rd_req,
  output rf_wr_t             wr_req,
  output exec_stat_t         stat
);

  logic                 s1_valid_r;
  logic [XLEN-1:0]      s1_instr_r;
  logic                 fwd1_r, fwd2_r;
  logic [XLEN-1:0]      fwd_val_r;
  logic [XLEN-1:0]      pc_r;

  logic                 out_valid_r;
  logic [XLEN-1:0]      out_exec_r, out_fetch_r, out_wval_r, out_tval_r;
  logic                 out_we_r, out_trap_r;
  logic [REG_IDX_W-1:0] out_dest_r;
  logic [CAUSE_W-1:0]   out_cause_r;

  logic                 s1_fire, accept;
  logic [6:0]           opcode;
  logic [2:0]           funct3;
  logic [6:0]           funct7;
  logic [REG_IDX_W-1:0] rd_idx;
  logic [XLEN-1:0]      op_a, op_b, pc_inc, value, next_pc;
  logic                 legal, we;

  assign s1_fire   = s1_valid_r && (!out_valid_r || out_res.ready);
  assign in_req.ready = !s1_valid_r || s1_fire;
  assign accept    = in_req.valid && in_req.ready;

  // Issue the operand reads as the request enters
  assign rd_req.en   = accept;
  assign rd_req.idx1 = in_req.instruction[19:15];
  assign rd_req.idx2 = in_req.instruction[24:20];

  assign opcode = s1_instr_r[6:0];
  assign funct3 = s1_instr_r[14:12];
  assign funct7 = s1_instr_r[31:25];
  assign rd_idx = s1_instr_r[11:7];

  // The memory read overlaps the write of the request ahead: take its value instead
  assign op_a   = fwd1_r ? fwd_val_r : rd_data.d1;
  assign op_b   = fwd2_r ? fwd_val_r : rd_data.d2;
  assign pc_inc = pc_r + PC_STEP;

  always_comb begin
    legal   = 1'b1;
    value   = '0;
    next_pc = pc_inc;
    case (opcode)
      OP_ADDI: begin
        legal = (funct3 == F3_ADD);
        value = op_a + imm_i(s1_instr_r);
      end
      OP_ADD: begin
        legal = (funct3 == F3_ADD) && (funct7 == F7_ADD);
        value = op_a + op_b;
      end
      OP_LUI: begin
        value = s1_instr_r & UPPER_MASK;
      end
      OP_JAL: begin
        value   = pc_inc;
        next_pc = pc_r + imm_j(s1_instr_r);
      end
      default: begin
        legal = 1'b0;
      end
    endcase
  end

  assign we = legal && (rd_idx != '0);

  assign wr_req.en   = s1_fire && we;
  assign wr_req.idx  = rd_idx;
  assign wr_req.data = value;

  assign stat.fire  = s1_fire;
  assign stat.legal = legal;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (accept) begin
      s1_valid_r <= 1'b1;
    end else if (s1_fire) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_instr_r <= in_req.instruction;
      fwd1_r     <= wr_req.en && (wr_req.idx == rd_req.idx1);
      fwd2_r     <= wr_req.en && (wr_req.idx == rd_req.idx2);
      fwd_val_r  <= value;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r <= RESET_VECTOR;
    end else if (pc_load.load) begin
      pc_r <= pc_load.value;
    end else if (s1_fire && legal) begin
      pc_r <= next_pc;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_fire) begin
      out_valid_r <= 1'b1;
    end else if (out_res.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      out_exec_r  <= pc_r;
      out_fetch_r <= legal ? next_pc : pc_r;
      out_we_r    <= we;
      out_dest_r  <= rd_idx;
      out_wval_r  <= legal ? value : '0;
      out_trap_r  <= !legal;
      out_cause_r <= legal ? CAUSE_NONE : CAUSE_ILLEGAL;
      out_tval_r  <= legal ? '0 : s1_instr_r;
    end
  end

  assign out_res.valid            = out_valid_r;
  assign out_res.executed_address = out_exec_r;
  assign out_res.fetch_address    = out_fetch_r;
  assign out_res.write_enable     = out_we_r;
  assign out_res.dest_index       = out_dest_r;
  assign out_res.write_value      = out_wval_r;
  assign out_res.trap_taken       = out_trap_r;
  assign out_res.trap_cause       = out_cause_r;
  assign out_res.trap_value       = out_tval_r;

endmodule

FILE: hdl/rv32_mini_execute_step.sv
// Top level of the RV32I subset execute step: APB register, register file, execute stage.
//
//   channel  | direction | handshake              | carries
//   ---------+-----------+------------------------+-------------------------------------
//   in_req   | in        | valid / ready          | instruction word at the current pc
//   out_res  | out       | valid / ready          | pc, next fetch, register write, trap
//   apb      | in        | psel, penable, pready  | start_address at byte address 0
//
// A request is read from the register file on acceptance and executed in the next
// cycle; its result is then captured by the output register, and one request is
// accepted every cycle while the output side keeps up.
// The register-file memory has a single write port and a registered read;
// a write landing in the same cycle as the next read is bypassed to that request.
// Reset (rst_n, synchronous) empties the stages, clears the register file valid bits,
// loads pc and start_address with RESET_VECTOR; a stalled output holds and backs up in_req.
module rv32_mini_execute_step import rvx_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  rvx_instr_if.sink             in_req,
  rvx_result_if.source          out_res,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [XLEN-1:0]       pwdata,
  output logic [XLEN-1:0]       prdata,
  output logic                  pready
);

`include "rv32_mini_execute_step_macros.svh"

  logic [XLEN-1:0] start_r;
  logic            cfg_wr, start_hit;
  logic            trap_held;
  pc_load_t        pc_load;
  rf_rd_t          rd_req;
  rf_wr_t          wr_req;
  rf_data_t        rd_data;
  exec_stat_t      stat;

  // Configuration port: no wait states
  assign pready    = 1'b1;
  assign cfg_wr    = psel && penable && pwrite && pready;
  assign start_hit = (paddr[CFG_ADDR_W-1:2] == CFG_REG_START);
  assign prdata    = start_hit ? start_r : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_r <= RESET_VECTOR;
    end else if (cfg_wr && start_hit) begin
      start_r <= pwdata;
    end
  end

  // Writing start_address also redirects the next fetch
  assign pc_load.load  = cfg_wr && start_hit;
  assign pc_load.value = pwdata;

  rvx_regfile u_regfile (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_req  (rd_req),
    .wr_req  (wr_req),
    .rd_data (rd_data)
  );

  rvx_exec_stage u_exec (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_req  (in_req),
    .out_res (out_res),
    .pc_load (pc_load),
    .rd_data (rd_data),
    .rd_req  (rd_req),
    .wr_req  (wr_req),
    .stat    (stat)
  );

  // A trapped result shows no write and a fetch address equal to its own pc
  assign trap_held = !out_res.write_enable &&
                     (out_res.fetch_address == out_res.executed_address);

  // x0 stays zero: the file is never written at index 0
  `RVX_ASSERT_NOW(a_no_x0_write, wr_req.en, wr_req.idx != '0, "write to x0")
  // Register writes only happen as a legal request leaves the execute stage
  `RVX_ASSERT_NOW(a_write_on_fire, wr_req.en, stat.fire && stat.legal, "stray write")
  // A finished request always shows up in the output register
  `RVX_ASSERT_NEXT(a_fire_to_out, stat.fire, out_res.valid, "result lost")
  // A trap leaves the pc and the register file alone
  `RVX_ASSERT_NOW(a_trap_no_effect, out_res.valid && out_res.trap_taken, trap_held, "trap changed state")

endmodule
